// File: sv/gtg_pkg.sv
// Package for the go-to-goal controller: widths, codes, constants and types.
// No dependencies.
package gtg_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int CORDIC_STEPS = 13;
  localparam logic signed [17:0] PI_Q = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q = 18'sd25736;

  typedef enum logic [1:0] {
    FUNC_POSE = 2'd0,
    FUNC_ENQ  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_MOVING   = 3'd0,
    ST_IDLE     = 3'd1,
    ST_CAPTURED = 3'd2,
    ST_QUEUED   = 3'd3,
    ST_DROPPED  = 3'd4,
    ST_POSE     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_LIN_GAIN = 2'd0,
    REG_ANG_GAIN = 2'd1,
    REG_RADIUS   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SETUP, S_ITER, S_MUL, S_DONE
  } state_t;

  // Entry of the target queue.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0] id;
  } target_t;

  // Arctangent table, Q3.12.
  function automatic logic signed [17:0] atan_tab(input logic [3:0] i);
    case (i)
      4'd0: atan_tab = 18'sd3217;
      4'd1: atan_tab = 18'sd1899;
      4'd2: atan_tab = 18'sd1003;
      4'd3: atan_tab = 18'sd509;
      4'd4: atan_tab = 18'sd256;
      4'd5: atan_tab = 18'sd128;
      4'd6: atan_tab = 18'sd64;
      4'd7: atan_tab = 18'sd32;
      4'd8: atan_tab = 18'sd16;
      4'd9: atan_tab = 18'sd8;
      4'd10: atan_tab = 18'sd4;
      4'd11: atan_tab = 18'sd2;
      4'd12: atan_tab = 18'sd1;
      default: atan_tab = 18'sd0;
    endcase
  endfunction

  // Single wrap into minus pi to pi.
  function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r > PI_Q) r = r - TWO_PI_Q;
    if (r < -PI_Q) r = r + TWO_PI_Q;
    wrap_once = r;
  endfunction
endpackage

// File: sv/gtg_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on gtg_pkg.
interface gtg_in_if import gtg_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] func;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  logic [7:0] target_id;
  modport source (output valid, func, pos_x, pos_y, heading, target_id, input ready);
  modport sink (input valid, func, pos_x, pos_y, heading, target_id, output ready);
endinterface

interface gtg_out_if import gtg_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [15:0] linear_speed;
  logic signed [15:0] angular_speed;
  logic [7:0] caught_id;
  modport source (output valid, status, linear_speed, angular_speed, caught_id, input ready);
  modport sink (input valid, status, linear_speed, angular_speed, caught_id, output ready);
endinterface

// File: sv/gtg_queue_ram.sv
// Target queue memory: one write port, one registered read port.
// Depends on gtg_pkg.
module gtg_queue_ram import gtg_pkg::*; (
  input  logic clk,
  input  logic we,
  input  logic [QW-1:0] waddr,
  input  target_t wdata,
  input  logic [QW-1:0] raddr,
  output target_t rdata
);
  target_t mem [QUEUE_DEPTH];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/gtg_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on gtg_pkg.
module gtg_isqrt import gtg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [33:0] radicand,
  output logic busy,
  output logic [16:0] root
);
  logic [33:0] rem;
  logic [33:0] res;
  logic [33:0] bitv;
  logic [33:0] trial;

  assign trial = res + bitv;
  assign root = res[16:0];

  // One result bit per cycle, seventeen result bits in all.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem <= radicand;
      res <= '0;
      bitv <= 34'h1 << 32;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[0]) busy <= 1'b0;
    end
  end
endmodule

// File: sv/go_to_goal_pursuit_controller_core.sv
// Go-to-goal controller top level: queue memory, pose, CORDIC and sequencer.
// Depends on gtg_pkg, gtg_if, gtg_queue_ram, gtg_isqrt.
// Sequence: pose, enqueue and idle ticks pass through read and done; a steering tick passes through
// read, setup, iterate (until both the CORDIC and the 17-step root finish), multiply and done.
// One item at a time: the next beat can be taken in the cycle after the result is. Reset
// (rst, synchronous) clears pose, queue pointers and gains to defaults.
module go_to_goal_pursuit_controller_core import gtg_pkg::*; (
  input  logic clk,
  input  logic rst,
  gtg_in_if.sink in_ch,
  gtg_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  state_t state, state_next;
  logic [15:0] linear_gain, angular_gain;
  logic [14:0] capture_radius;
  logic [QW-1:0] head, tail;
  logic [CW-1:0] count;
  logic signed [15:0] rob_x, rob_y, rob_h;
  logic pose_known;
  logic [1:0] func;
  logic signed [15:0] in_x, in_y, in_h;
  logic enq_ok;
  target_t rdata;
  target_t wr_entry;
  logic ram_we;
  logic signed [16:0] dx, dy;
  logic [15:0] adx, ady;
  logic [31:0] dx_sq, dy_sq;
  logic signed [31:0] cx, cy;
  logic signed [17:0] cz;
  logic [3:0] iter;
  logic sq_start, sq_busy;
  logic [16:0] distance;
  logic [33:0] radicand;
  logic signed [17:0] err;
  logic [32:0] lin_prod;
  logic signed [34:0] ang_prod;
  logic signed [25:0] ang_sh;
  logic [2:0] status_r;
  logic [15:0] lin_r;
  logic signed [15:0] ang_r;
  logic [7:0] id_r;
  logic out_valid;
  logic accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.status = status_r;
  assign out_ch.linear_speed = lin_r;
  assign out_ch.angular_speed = ang_r;
  assign out_ch.caught_id = id_r;

  // Queue memory; enqueue writes at the tail, tick reads the head.
  assign ram_we = accept && (in_ch.func == FUNC_ENQ) && (count != CW'(QUEUE_DEPTH));
  assign wr_entry = '{x: in_ch.pos_x, y: in_ch.pos_y, id: in_ch.target_id};
  gtg_queue_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(tail),
    .wdata(wr_entry),
    .raddr(head), .rdata(rdata)
  );

  // Squared distance from the offset magnitudes.
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];
  assign dx_sq = adx * adx;
  assign dy_sq = ady * ady;
  assign radicand = {2'b00, dx_sq} + {2'b00, dy_sq};
  assign sq_start = (state == S_SETUP);
  gtg_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(radicand),
    .busy(sq_busy), .root(distance)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain <= 16'd768;
      angular_gain <= 16'd768;
      capture_radius <= 15'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIN_GAIN: linear_gain <= cfg_data;
        REG_ANG_GAIN: angular_gain <= cfg_data;
        REG_RADIUS: capture_radius <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: begin
        if (func == FUNC_TICK && pose_known && count != '0) state_next = S_SETUP;
        else state_next = S_DONE;
      end
      S_SETUP: state_next = S_ITER;
      S_ITER: if (iter == 4'(CORDIC_STEPS) && !sq_busy) state_next = S_MUL;
      S_MUL: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign dx = 17'(rdata.x) - 17'(rob_x);
  assign dy = 17'(rdata.y) - 17'(rob_y);
  assign err = wrap_once(cz - wrap_once(18'(rob_h)));
  assign ang_sh = 26'(ang_prod >>> 9);

  // Datapath and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; tail <= '0; count <= '0;
      pose_known <= 1'b0; rob_x <= '0; rob_y <= '0; rob_h <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (accept) begin
        func <= in_ch.func; in_x <= in_ch.pos_x; in_y <= in_ch.pos_y;
        in_h <= in_ch.heading;
        enq_ok <= ram_we;
        if (ram_we) begin
          tail <= QW'((32'(tail) + 1) % QUEUE_DEPTH);
          count <= count + 1'b1;
        end
      end
      case (state)
        S_READ: begin
          lin_r <= '0; ang_r <= '0; id_r <= '0;
          case (func)
            FUNC_POSE: begin
              rob_x <= in_x; rob_y <= in_y; rob_h <= in_h;
              pose_known <= 1'b1; status_r <= ST_POSE;
            end
            FUNC_ENQ: status_r <= enq_ok ? ST_QUEUED : ST_DROPPED;
            default: status_r <= ST_IDLE;
          endcase
        end
        S_SETUP: begin
          iter <= '0;
          if (dx < 0) begin
            cx <= -(32'(dx) <<< 12); cy <= -(32'(dy) <<< 12);
            cz <= (dy >= 0) ? PI_Q : -PI_Q;
          end else begin
            cx <= 32'(dx) <<< 12; cy <= 32'(dy) <<< 12; cz <= '0;
          end
        end
        S_ITER: begin
          if (iter != 4'(CORDIC_STEPS)) begin
            if (cy >= 0) begin
              cx <= cx + (cy >>> iter); cy <= cy - (cx >>> iter);
              cz <= cz + atan_tab(iter);
            end else begin
              cx <= cx - (cy >>> iter); cy <= cy + (cx >>> iter);
              cz <= cz - atan_tab(iter);
            end
            iter <= iter + 1'b1;
          end
          lin_prod <= 33'(linear_gain) * 33'(distance);
          ang_prod <= 35'(signed'({1'b0, angular_gain})) * 35'(err);
        end
        S_MUL: begin
          if (distance > 17'(capture_radius)) begin
            status_r <= ST_MOVING;
            lin_r <= (lin_prod[32:8] > 25'd65535) ? 16'hFFFF : lin_prod[23:8];
            if (ang_sh > 26'sd32767) ang_r <= 16'sh7FFF;
            else if (ang_sh < -26'sd32768) ang_r <= 16'sh8000;
            else ang_r <= ang_sh[15:0];
          end else begin
            status_r <= ST_CAPTURED;
            id_r <= rdata.id;
            head <= QW'((32'(head) + 1) % QUEUE_DEPTH);
            count <= count - 1'b1;
          end
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // The queue count never exceeds its depth.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(QUEUE_DEPTH))
    else $error("queue count overflow");
  // No new beat is taken while a result waits.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ch.ready)
    else $error("input taken while result pending");
  // A capture pops exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && distance <= 17'(capture_radius)) |=> count == $past(count) - 1'b1)
    else $error("capture did not pop");
endmodule
